// ===== hdl/terminal_key_escape_decoder_macros.svh =====
// Assertion macros for the terminal key escape decoder.
// Included by the RTL files that carry concurrent checks; no other dependency.
`ifndef TERMINAL_KEY_ESCAPE_DECODER_MACROS_SVH
`define TERMINAL_KEY_ESCAPE_DECODER_MACROS_SVH
`ifndef SYNTH
// expr holds at every clock edge outside reset
`define TKED_ASSERT(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
// ante at one edge implies cons at the next edge
`define TKED_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TKED_ASSERT(name, expr)
`define TKED_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== hdl/tked_pkg.sv =====
// Package of the terminal key escape decoder: byte codes, register indexes
// and the constant table of known key sequences. No dependencies.
`default_nettype none

package tked_pkg;

  localparam int unsigned KEY_COUNT   = 61;
  localparam int unsigned KEY_IDX_W   = 6;
  localparam int unsigned KEY_MAX_LEN = 5;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOORWAY = 2'd1;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_QM   = 8'h3F;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_E0   = 8'hE0;

  typedef struct packed {
    logic [2:0]                   len;
    logic [KEY_MAX_LEN-1:0][7:0]  text;  // text[0] is ESC
    logic [7:0]                   code;
  } key_entry_t;

  function automatic key_entry_t mk(input logic [2:0] n, input logic [7:0] c1,
                                    input logic [7:0] c2, input logic [7:0] c3,
                                    input logic [7:0] c4, input logic [7:0] code);
    key_entry_t e;
    e.len  = n;
    e.text = {c4, c3, c2, c1, CH_ESC};
    e.code = code;
    return e;
  endfunction

  function automatic key_entry_t key_rom(input logic [KEY_IDX_W-1:0] idx);
    key_entry_t e;
    e = '0;
    case (idx)
      6'd0:  e = mk(3'd2, "A", 8'h00, 8'h00, 8'h00, 8'h48);
      6'd1:  e = mk(3'd2, "B", 8'h00, 8'h00, 8'h00, 8'h50);
      6'd2:  e = mk(3'd2, "C", 8'h00, 8'h00, 8'h00, 8'h4d);
      6'd3:  e = mk(3'd2, "D", 8'h00, 8'h00, 8'h00, 8'h4b);
      6'd4:  e = mk(3'd2, "H", 8'h00, 8'h00, 8'h00, 8'h47);
      6'd5:  e = mk(3'd2, "K", 8'h00, 8'h00, 8'h00, 8'h4f);
      6'd6:  e = mk(3'd2, "P", 8'h00, 8'h00, 8'h00, 8'h3b);
      6'd7:  e = mk(3'd2, "Q", 8'h00, 8'h00, 8'h00, 8'h3c);
      6'd8:  e = mk(3'd3, "?", "w", 8'h00, 8'h00, 8'h3d);
      6'd9:  e = mk(3'd3, "?", "x", 8'h00, 8'h00, 8'h3e);
      6'd10: e = mk(3'd3, "?", "t", 8'h00, 8'h00, 8'h3f);
      6'd11: e = mk(3'd3, "?", "u", 8'h00, 8'h00, 8'h40);
      6'd12: e = mk(3'd3, "?", "q", 8'h00, 8'h00, 8'h41);
      6'd13: e = mk(3'd3, "?", "r", 8'h00, 8'h00, 8'h42);
      6'd14: e = mk(3'd3, "?", "p", 8'h00, 8'h00, 8'h43);
      6'd15: e = mk(3'd3, "[", "A", 8'h00, 8'h00, 8'h48);
      6'd16: e = mk(3'd3, "[", "B", 8'h00, 8'h00, 8'h50);
      6'd17: e = mk(3'd3, "[", "C", 8'h00, 8'h00, 8'h4d);
      6'd18: e = mk(3'd3, "[", "D", 8'h00, 8'h00, 8'h4b);
      6'd19: e = mk(3'd3, "[", "M", 8'h00, 8'h00, 8'h49);
      6'd20: e = mk(3'd3, "[", "H", 8'h00, 8'h00, 8'h47);
      6'd21: e = mk(3'd3, "[", "K", 8'h00, 8'h00, 8'h4f);
      6'd22: e = mk(3'd3, "O", "P", 8'h00, 8'h00, 8'h3b);
      6'd23: e = mk(3'd3, "O", "Q", 8'h00, 8'h00, 8'h3c);
      6'd24: e = mk(3'd3, "O", "R", 8'h00, 8'h00, 8'h3d);
      6'd25: e = mk(3'd3, "O", "S", 8'h00, 8'h00, 8'h3e);
      6'd26: e = mk(3'd4, "[", "1", "~", 8'h00, 8'h47);
      6'd27: e = mk(3'd4, "[", "2", "~", 8'h00, 8'h52);
      6'd28: e = mk(3'd4, "[", "3", "~", 8'h00, 8'h53);
      6'd29: e = mk(3'd4, "[", "4", "~", 8'h00, 8'h4f);
      6'd30: e = mk(3'd4, "[", "5", "~", 8'h00, 8'h49);
      6'd31: e = mk(3'd4, "[", "6", "~", 8'h00, 8'h51);
      6'd32: e = mk(3'd5, "[", "1", "7", "~", 8'h40);
      6'd33: e = mk(3'd5, "[", "1", "8", "~", 8'h41);
      6'd34: e = mk(3'd5, "[", "1", "9", "~", 8'h42);
      6'd35: e = mk(3'd5, "[", "2", "0", "~", 8'h43);
      6'd36: e = mk(3'd5, "[", "2", "1", "~", 8'h44);
      6'd37: e = mk(3'd5, "[", "2", "3", "~", 8'h85);
      6'd38: e = mk(3'd5, "[", "2", "4", "~", 8'h86);
      6'd39: e = mk(3'd5, "[", "1", "5", "~", 8'h3f);
      6'd40: e = mk(3'd5, "[", "1", "1", "~", 8'h3b);
      6'd41: e = mk(3'd5, "[", "1", "2", "~", 8'h3c);
      6'd42: e = mk(3'd5, "[", "1", "3", "~", 8'h3d);
      6'd43: e = mk(3'd5, "[", "1", "4", "~", 8'h3e);
      6'd44: e = mk(3'd3, "[", "L", 8'h00, 8'h00, 8'h47);
      6'd45: e = mk(3'd3, "O", "w", 8'h00, 8'h00, 8'h3d);
      6'd46: e = mk(3'd3, "O", "x", 8'h00, 8'h00, 8'h3e);
      6'd47: e = mk(3'd3, "O", "t", 8'h00, 8'h00, 8'h3f);
      6'd48: e = mk(3'd3, "O", "u", 8'h00, 8'h00, 8'h40);
      6'd49: e = mk(3'd3, "O", "q", 8'h00, 8'h00, 8'h41);
      6'd50: e = mk(3'd3, "O", "r", 8'h00, 8'h00, 8'h42);
      6'd51: e = mk(3'd3, "O", "p", 8'h00, 8'h00, 8'h43);
      6'd52: e = mk(3'd3, "[", "V", 8'h00, 8'h00, 8'h49);
      6'd53: e = mk(3'd3, "[", "U", 8'h00, 8'h00, 8'h51);
      6'd54: e = mk(3'd3, "[", "@", 8'h00, 8'h00, 8'h52);
      6'd55: e = mk(3'd3, "O", "A", 8'h00, 8'h00, 8'h48);
      6'd56: e = mk(3'd3, "O", "B", 8'h00, 8'h00, 8'h50);
      6'd57: e = mk(3'd3, "O", "C", 8'h00, 8'h00, 8'h4d);
      6'd58: e = mk(3'd3, "O", "D", 8'h00, 8'h00, 8'h4b);
      6'd59: e = mk(3'd3, "O", "H", 8'h00, 8'h00, 8'h47);
      6'd60: e = mk(3'd3, "O", "K", 8'h00, 8'h00, 8'h4f);
      default: e = '0;  // len 0 never matches a live sequence
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/terminal_key_escape_decoder.sv =====
// Terminal key escape decoder, top level.
// Depends on tked_pkg, tked_ram and terminal_key_escape_decoder_macros.svh.
//
// Usage:
// - Input channel (in_valid_i/in_ready_o): kind_i = 0 carries a received byte
//   in rx_byte_i, kind_i = 1 carries one idle tick.
// - Output channel (out_valid_o/out_ready_i): key bytes (result_kind_o = 0)
//   or screen size updates (result_kind_o = 1), each with the current size;
//   last_o marks the final result caused by one input transfer.
// - Config port: cfg_we_i writes cfg_wdata_i to register cfg_index_i
//   (0 = timeout ticks, 1 = doorway enable) at once; other indexes ignored.
// Timing: one item is handled at a time; in_ready_o is high only while the
// sequencer is idle. A plain byte gives its result via state ST_EMIT_B and
// the output register. A finished escape sequence is looked up against the
// 61-entry key table one entry per cycle. A raw replay or a position report
// reads the sequence buffer RAM back byte by byte, each through a read state
// and an output or check state, set by the registered RAM read port. Bytes
// that only extend a sequence, unexpired ticks and dropped bytes stay in idle.
// Reset: parse state idle, timeout 500, doorway off, screen 24 x 80. The
// buffer RAM needs no clearing; only written entries are ever read.
// Output stall: the output register holds its result until taken; a state
// that loads a result waits for it, but idle still takes new input.
`default_nettype none

module terminal_key_escape_decoder #(
  parameter int unsigned SEQ_DEPTH = 64
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire                            kind_i,
  input  wire  [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic                           result_kind_o,
  output logic [7:0]                     key_value_o,
  output logic [7:0]                     rows_o,
  output logic [7:0]                     cols_o,
  output logic                           last_o,
  input  wire                            cfg_we_i,
  input  wire  [tked_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [15:0]                    cfg_wdata_i
);

  localparam int unsigned AW = $clog2(SEQ_DEPTH);
  localparam int unsigned KW = tked_pkg::KEY_IDX_W;
  localparam int unsigned HL = tked_pkg::KEY_MAX_LEN;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_NUL    = 2'd2,
    MODE_NUL_E0 = 2'd3
  } mode_e;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_MATCH   = 10'b0000000010,
    ST_EMIT_A  = 10'b0000000100,
    ST_EMIT_B  = 10'b0000001000,
    ST_REP_RD  = 10'b0000010000,
    ST_REP_OUT = 10'b0000100000,
    ST_POS_RD  = 10'b0001000000,
    ST_POS_CHK = 10'b0010000000,
    ST_POS_END = 10'b0100000000,
    ST_EMIT_S  = 10'b1000000000
  } state_e;

  // position report parse phases
  localparam logic [1:0] PH_ROW  = 2'd0;
  localparam logic [1:0] PH_COL  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  state_e                state_q, state_d;
  mode_e                 mode_q, mode_d;
  logic [AW-1:0]         len_q, len_d;
  logic [15:0]           timer_q, timer_d;
  logic [7:0]            rows_q, rows_d, cols_q, cols_d;
  logic [15:0]           tmo_q;
  logic                  door_q;
  logic [HL-1:0][7:0]    head_q, head_d;
  logic [7:0]            byte_q, byte_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [KW-1:0]         kidx_q, kidx_d;
  logic [9:0]            row_q, row_d, col_q, col_d;
  logic [1:0]            phase_q, phase_d;
  logic                  bad_q, bad_d;

  logic                  out_valid_q, out_kind_q, out_last_q;
  logic [7:0]            out_val_q, out_rows_q, out_cols_q;
  logic                  out_free, load;
  logic                  ld_kind, ld_last;
  logic [7:0]            ld_val;

  logic                  ram_we;
  logic [7:0]            ram_rdata;
  logic [AW:0]           len_inc;
  logic                  ch_ext;
  tked_pkg::key_entry_t  ent;
  logic                  hit;
  logic                  c_digit;
  logic [13:0]           num_in, num_prod;
  logic [9:0]            num_sat;
  logic [7:0]            row_fin, col_fin;

  // buffer RAM
  tked_ram #(
    .WIDTH (8),
    .DEPTH (SEQ_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (len_q),
    .wdata_i (rx_byte_i),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign len_inc    = {1'b0, len_q} + (AW+1)'(1);
  assign ch_ext     = ((rx_byte_i >= tked_pkg::CH_0) && (rx_byte_i <= tked_pkg::CH_9)) ||
                      (rx_byte_i == tked_pkg::CH_SEMI) || (rx_byte_i == tked_pkg::CH_QM) ||
                      ((len_inc == (AW+1)'(2)) &&
                       ((rx_byte_i == tked_pkg::CH_LBR) || (rx_byte_i == tked_pkg::CH_O)));

  // table compare for the current entry
  assign ent = tked_pkg::key_rom(kidx_q);
  always_comb begin
    hit = (AW'(ent.len) == len_q);
    for (int j = 0; j < HL; j++) begin
      if ((3'(j) < ent.len) && (head_q[j] != ent.text[j])) begin
        hit = 1'b0;
      end
    end
  end

  // decimal accumulate for the position report, saturating at 1000
  assign c_digit  = (ram_rdata >= tked_pkg::CH_0) && (ram_rdata <= tked_pkg::CH_9);
  assign num_in   = {4'b0, (phase_q == PH_ROW) ? row_q : col_q};
  assign num_prod = num_in * 14'd10 + {10'b0, ram_rdata[3:0]};
  assign num_sat  = (num_prod > 14'd1000) ? 10'd1000 : num_prod[9:0];
  assign row_fin  = (row_q > 10'd255) ? 8'hFF : row_q[7:0];
  assign col_fin  = (col_q > 10'd255) ? 8'hFF : col_q[7:0];

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    len_d   = len_q;
    timer_d = timer_q;
    rows_d  = rows_q;
    cols_d  = cols_q;
    head_d  = head_q;
    byte_d  = byte_q;
    idx_d   = idx_q;
    kidx_d  = kidx_q;
    row_d   = row_q;
    col_d   = col_q;
    phase_d = phase_q;
    bad_d   = bad_q;
    ram_we  = 1'b0;
    load    = 1'b0;
    ld_kind = 1'b0;
    ld_val  = 8'h00;
    ld_last = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (kind_i) begin
            if (mode_q == MODE_ESC) begin
              if (timer_q <= 16'd1) begin
                idx_d   = '0;
                state_d = ST_REP_RD;
              end else begin
                timer_d = timer_q - 16'd1;
              end
            end
          end else begin
            unique case (mode_q)
              MODE_NUL_E0: begin
                byte_d  = rx_byte_i;
                mode_d  = MODE_IDLE;
                state_d = ST_EMIT_A;
              end
              MODE_NUL: begin
                if (rx_byte_i == tked_pkg::CH_E0) begin
                  mode_d = MODE_NUL_E0;
                end else begin
                  byte_d  = rx_byte_i;
                  mode_d  = MODE_IDLE;
                  state_d = ST_EMIT_A;
                end
              end
              MODE_ESC: begin
                ram_we  = 1'b1;
                len_d   = len_inc[AW-1:0];
                timer_d = tmo_q;
                byte_d  = rx_byte_i;
                for (int j = 0; j < HL; j++) begin
                  if (len_q == AW'(j)) begin
                    head_d[j] = rx_byte_i;
                  end
                end
                if (len_inc >= (AW+1)'(SEQ_DEPTH - 2)) begin
                  // buffer full: replay everything, this byte included
                  idx_d   = '0;
                  state_d = ST_REP_RD;
                end else if (!ch_ext) begin
                  kidx_d  = '0;
                  state_d = ST_MATCH;
                end
              end
              default: begin
                if (rx_byte_i == tked_pkg::CH_ESC) begin
                  ram_we    = 1'b1;
                  head_d[0] = rx_byte_i;
                  len_d     = AW'(1);
                  mode_d    = MODE_ESC;
                  timer_d   = tmo_q;
                end else if (rx_byte_i == tked_pkg::CH_LF) begin
                  // dropped
                end else if (door_q && (rx_byte_i == tked_pkg::CH_NUL)) begin
                  mode_d = MODE_NUL;
                end else begin
                  byte_d  = rx_byte_i;
                  state_d = ST_EMIT_B;
                end
              end
            endcase
          end
        end
      end

      ST_MATCH: begin
        if (hit) begin
          byte_d  = ent.code;
          mode_d  = MODE_IDLE;
          len_d   = '0;
          timer_d = '0;
          state_d = ST_EMIT_A;
        end else if (kidx_q == KW'(tked_pkg::KEY_COUNT - 1)) begin
          idx_d = '0;
          if (byte_q == tked_pkg::CH_R) begin
            row_d   = '0;
            col_d   = '0;
            phase_d = PH_ROW;
            bad_d   = 1'b0;
            state_d = ST_POS_RD;
          end else begin
            state_d = ST_REP_RD;
          end
        end else begin
          kidx_d = kidx_q + KW'(1);
        end
      end

      ST_EMIT_A: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_EMIT_B;
        end
      end

      ST_EMIT_B: begin
        if (out_free) begin
          load    = 1'b1;
          ld_val  = byte_q;
          ld_last = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_REP_RD: begin
        state_d = ST_REP_OUT;
      end

      ST_REP_OUT: begin
        if (out_free) begin
          load   = 1'b1;
          ld_val = ram_rdata;
          if (idx_q == len_q - AW'(1)) begin
            ld_last = 1'b1;
            mode_d  = MODE_IDLE;
            len_d   = '0;
            timer_d = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = ST_REP_RD;
          end
        end
      end

      ST_POS_RD: begin
        state_d = ST_POS_CHK;
      end

      ST_POS_CHK: begin
        if (!(c_digit || (ram_rdata == tked_pkg::CH_ESC) || (ram_rdata == tked_pkg::CH_LBR) ||
              (ram_rdata == tked_pkg::CH_SEMI) || (ram_rdata == tked_pkg::CH_R))) begin
          bad_d = 1'b1;
        end
        if (idx_q >= AW'(2)) begin
          case (phase_q)
            PH_ROW: begin
              if (c_digit) begin
                row_d = num_sat;
              end else if (ram_rdata == tked_pkg::CH_SEMI) begin
                phase_d = PH_COL;
              end else begin
                phase_d = PH_DONE;
              end
            end
            PH_COL: begin
              if (c_digit) begin
                col_d = num_sat;
              end else begin
                phase_d = PH_DONE;
              end
            end
            default: ;
          endcase
        end
        if (idx_q == len_q - AW'(1)) begin
          state_d = ST_POS_END;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = ST_POS_RD;
        end
      end

      ST_POS_END: begin
        mode_d  = MODE_IDLE;
        len_d   = '0;
        timer_d = '0;
        state_d = ST_IDLE;
        if (!bad_q && (row_fin > rows_q)) begin
          rows_d = row_fin;
          if (col_fin > cols_q) begin
            cols_d = col_fin;
          end
          state_d = ST_EMIT_S;
        end
      end

      ST_EMIT_S: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = 1'b1;
          ld_last = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_IDLE;
      len_q       <= '0;
      timer_q     <= '0;
      rows_q      <= 8'd24;
      cols_q      <= 8'd80;
      tmo_q       <= 16'd500;
      door_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      len_q   <= len_d;
      timer_q <= timer_d;
      rows_q  <= rows_d;
      cols_q  <= cols_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          tked_pkg::CFG_TIMEOUT: tmo_q  <= cfg_wdata_i;
          tked_pkg::CFG_DOORWAY: door_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    byte_q  <= byte_d;
    idx_q   <= idx_d;
    kidx_q  <= kidx_d;
    row_q   <= row_d;
    col_q   <= col_d;
    phase_q <= phase_d;
    bad_q   <= bad_d;
    if (load) begin
      out_kind_q <= ld_kind;
      out_val_q  <= ld_val;
      out_last_q <= ld_last;
      out_rows_q <= rows_q;
      out_cols_q <= cols_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign key_value_o   = out_val_q;
  assign rows_o        = out_rows_q;
  assign cols_o        = out_cols_q;
  assign last_o        = out_last_q;

`include "terminal_key_escape_decoder_macros.svh"

  // fill reaches the full mark only while the overflow replay runs
  `TKED_ASSERT(a_len_bound, ({1'b0, len_q} <= (AW+1)'(SEQ_DEPTH - 2)))
  // outside an escape sequence the buffer is empty
  `TKED_ASSERT(a_len_mode, ((mode_q == MODE_ESC) || (len_q == '0)))
  // screen size only grows
  `TKED_ASSERT_NEXT(a_rows_grow, 1'b1, ((rows_q >= $past(rows_q)) && (cols_q >= $past(cols_q))))

endmodule

`default_nettype wire

// ===== hdl/tked_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the escape sequence buffer; no dependencies.
`default_nettype none

module tked_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== tb/tb_terminal_key_escape_decoder.sv =====
// Testbench for terminal_key_escape_decoder: a scoreboard class predicts the key bytes
// and screen size updates for every input transfer. Directed and random byte and tick streams.
// Depends on tked_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module tb_terminal_key_escape_decoder;

  localparam int unsigned BUF_DEPTH   = 64;
  localparam int unsigned DRAIN_WAIT  = 200;   // lookup plus longest replay, in cycles
  localparam int unsigned ITEM_TARGET = 370;
  localparam int unsigned N_KEYS      = tked_pkg::KEY_COUNT;
  localparam logic [tked_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // not a register, ignored
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam logic RES_KEY   = 1'b0;
  localparam logic RES_SIZE  = 1'b1;

  typedef enum logic [1:0] {P_IDLE, P_ESC, P_NUL, P_NUL_E0} parse_e;

  typedef struct {
    logic       kind;
    logic [7:0] value;
    logic [7:0] rows;
    logic [7:0] cols;
    logic       last;
  } key_result_t;

  // Known sequences, written without the leading ESC, with their scan codes.
  string      seq_tail[N_KEYS] = '{"A", "B", "C", "D", "H", "K", "P", "Q",
    "?w", "?x", "?t", "?u", "?q", "?r", "?p",
    "[A", "[B", "[C", "[D", "[M", "[H", "[K", "OP", "OQ", "OR", "OS",
    "[1~", "[2~", "[3~", "[4~", "[5~", "[6~",
    "[17~", "[18~", "[19~", "[20~", "[21~", "[23~", "[24~", "[15~",
    "[11~", "[12~", "[13~", "[14~",
    "[L", "Ow", "Ox", "Ot", "Ou", "Oq", "Or", "Op", "[V", "[U", "[@",
    "OA", "OB", "OC", "OD", "OH", "OK"};
  logic [7:0] seq_code[N_KEYS] = '{8'h48, 8'h50, 8'h4d, 8'h4b, 8'h47, 8'h4f, 8'h3b, 8'h3c,
    8'h3d, 8'h3e, 8'h3f, 8'h40, 8'h41, 8'h42, 8'h43,
    8'h48, 8'h50, 8'h4d, 8'h4b, 8'h49, 8'h47, 8'h4f, 8'h3b, 8'h3c, 8'h3d, 8'h3e,
    8'h47, 8'h52, 8'h53, 8'h4f, 8'h49, 8'h51,
    8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h85, 8'h86, 8'h3f,
    8'h3b, 8'h3c, 8'h3d, 8'h3e,
    8'h47, 8'h3d, 8'h3e, 8'h3f, 8'h40, 8'h41, 8'h42, 8'h43, 8'h49, 8'h51, 8'h52,
    8'h48, 8'h50, 8'h4d, 8'h4b, 8'h47, 8'h4f};

  class key_scoreboard;
    logic [15:0] timeout_ticks;
    logic        doorway_on;
    parse_e      mode;
    logic [7:0]  seq_buf[BUF_DEPTH];
    int unsigned seq_len;
    int unsigned idle_timer;
    int unsigned rows;
    int unsigned cols;
    logic        step_kind[$];
    logic [7:0]  step_value[$];
    key_result_t expected_keys[$];
    int          errors;
    int          checked;
    int          key_hits;
    int          replays;
    int          size_updates;

    function new();
      timeout_ticks = 16'd500;
      doorway_on    = 1'b0;
      mode          = P_IDLE;
      seq_len       = 0;
      idle_timer    = 0;
      rows          = 24;
      cols          = 80;
      errors        = 0;
      checked       = 0;
      key_hits      = 0;
      replays       = 0;
      size_updates  = 0;
    endfunction

    function void write_reg(logic [tked_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
      if (idx == tked_pkg::CFG_TIMEOUT) timeout_ticks = data;
      else if (idx == tked_pkg::CFG_DOORWAY) doorway_on = data[0];
    endfunction

    function void push_key(logic k, logic [7:0] v);
      step_kind.push_back(k);
      step_value.push_back(v);
    endfunction

    function void flush_raw();
      for (int unsigned i = 0; i < seq_len; i++) push_key(RES_KEY, seq_buf[i]);
      replays++;
      seq_len    = 0;
      mode       = P_IDLE;
      idle_timer = 0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= tked_pkg::CH_0 && c <= tked_pkg::CH_9;
    endfunction

    function int lookup_key();
      int unsigned n;
      bit same;
      for (int k = 0; k < N_KEYS; k++) begin
        n = seq_tail[k].len();
        if (n + 1 == seq_len) begin
          same = 1'b1;
          for (int unsigned j = 0; j < n; j++)
            if (seq_buf[j+1] != seq_tail[k][j]) same = 1'b0;
          if (same) return k;
        end
      end
      return -1;
    endfunction

    function int unsigned parse_num(inout int unsigned idx);
      int unsigned v;
      v = 0;
      while (idx < seq_len && is_digit(seq_buf[idx])) begin
        v = v * 10 + (seq_buf[idx] - tked_pkg::CH_0);
        if (v > 1000) v = 1000;
        idx++;
      end
      return (v > 255) ? 255 : v;
    endfunction

    // Cursor position report: grows rows, and cols only when rows grew.
    function void size_report();
      int unsigned i;
      int unsigned r;
      int unsigned c;
      logic [7:0]  b;
      for (i = 0; i < seq_len; i++) begin
        b = seq_buf[i];
        if (!(b == tked_pkg::CH_ESC || b == tked_pkg::CH_LBR || b == tked_pkg::CH_SEMI ||
              b == tked_pkg::CH_R || is_digit(b))) return;
      end
      i = 2;
      r = parse_num(i);
      if (r > rows) begin
        rows = r;
        if (i < seq_len && seq_buf[i] == tked_pkg::CH_SEMI) begin
          i++;
          c = parse_num(i);
          if (c > cols) cols = c;
        end
        push_key(RES_SIZE, 8'h00);
        size_updates++;
      end
    endfunction

    function void escape_char(logic [7:0] ch);
      int k;
      if (seq_len < BUF_DEPTH) begin
        seq_buf[seq_len] = ch;
        seq_len++;
      end
      idle_timer = timeout_ticks;
      if (seq_len >= BUF_DEPTH - 2) begin
        flush_raw();
        return;
      end
      if (is_digit(ch) || ch == tked_pkg::CH_SEMI || ch == tked_pkg::CH_QM ||
          (seq_len == 2 && (ch == tked_pkg::CH_LBR || ch == tked_pkg::CH_O))) return;
      k = lookup_key();
      if (k >= 0) begin
        push_key(RES_KEY, 8'h00);
        push_key(RES_KEY, seq_code[k]);
        key_hits++;
      end else if (ch == tked_pkg::CH_R) begin
        size_report();
      end else begin
        flush_raw();
        return;
      end
      seq_len    = 0;
      mode       = P_IDLE;
      idle_timer = 0;
    endfunction

    // Called on every accepted input transfer.
    function void note_input(logic kind, logic [7:0] ch);
      key_result_t r;
      step_kind.delete();
      step_value.delete();
      if (kind == KIND_TICK) begin
        if (mode == P_ESC) begin
          if (idle_timer <= 1) flush_raw();
          else idle_timer--;
        end
      end else if (mode == P_NUL_E0) begin
        push_key(RES_KEY, 8'h00);
        push_key(RES_KEY, ch);
        mode = P_IDLE;
      end else if (mode == P_NUL) begin
        if (ch == tked_pkg::CH_E0) begin
          mode = P_NUL_E0;
        end else begin
          push_key(RES_KEY, 8'h00);
          push_key(RES_KEY, ch);
          mode = P_IDLE;
        end
      end else if (mode == P_ESC) begin
        escape_char(ch);
      end else if (ch == tked_pkg::CH_ESC) begin
        seq_buf[0] = ch;
        seq_len    = 1;
        mode       = P_ESC;
        idle_timer = timeout_ticks;
      end else if (ch == tked_pkg::CH_LF) begin
        // line feed is dropped
      end else if (doorway_on && ch == tked_pkg::CH_NUL) begin
        mode = P_NUL;
      end else begin
        push_key(RES_KEY, ch);
      end
      foreach (step_kind[i]) begin
        r.kind  = step_kind[i];
        r.value = step_value[i];
        r.rows  = rows[7:0];
        r.cols  = cols[7:0];
        r.last  = (i == step_kind.size() - 1);
        expected_keys.push_back(r);
      end
    endfunction

    function void check_result(key_result_t got);
      key_result_t e;
      checked++;
      if (expected_keys.size() == 0) begin
        $error("result with nothing expected: kind %0d value %02h", got.kind, got.value);
        errors++;
        return;
      end
      e = expected_keys.pop_front();
      if (got.kind != e.kind) begin
        $error("result_kind: expected %0d, actual %0d", e.kind, got.kind); errors++;
      end
      if (got.value != e.value) begin
        $error("key_value: expected %02h, actual %02h", e.value, got.value); errors++;
      end
      if (got.rows != e.rows) begin
        $error("rows: expected %0d, actual %0d", e.rows, got.rows); errors++;
      end
      if (got.cols != e.cols) begin
        $error("cols: expected %0d, actual %0d", e.cols, got.cols); errors++;
      end
      if (got.last != e.last) begin
        $error("last: expected %0d, actual %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           kind_i;
  logic [7:0]                     rx_byte_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic                           result_kind_o;
  logic [7:0]                     key_value_o;
  logic [7:0]                     rows_o;
  logic [7:0]                     cols_o;
  logic                           last_o;
  logic                           cfg_we_i;
  logic [tked_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0]                    cfg_wdata_i;

  key_scoreboard sb;
  int          items_sent;
  int          burst_left;
  int unsigned rx_cycle;

  terminal_key_escape_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .key_value_o   (key_value_o),
    .rows_o        (rows_o),
    .cols_o        (cols_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop; far beyond the slowest legal run.
  initial begin
    #8ms;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: ready pattern is drawn anew at random from four modes; one long hold-off
  // fills the block so that its input stalls while items keep coming.
  initial begin
    int stall_mode;
    stall_mode  = 0;
    rx_cycle    = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (rx_cycle % 64 == 0) stall_mode = $urandom_range(3);
      if (rx_cycle >= 1500 && rx_cycle < 1900) out_ready_i = 1'b0;
      else case (stall_mode)
        0:       out_ready_i = 1'b1;
        1:       out_ready_i = 1'($urandom_range(1));
        2:       out_ready_i = ($urandom_range(3) == 0);
        default: out_ready_i = (rx_cycle % 5 != 0);
      endcase
    end
  end

  // Output monitor: a result transfers when valid and ready meet at the edge.
  always @(posedge clk_i) begin
    key_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind  = result_kind_o;
      got.value = key_value_o;
      got.rows  = rows_o;
      got.cols  = cols_o;
      got.last  = last_o;
      sb.check_result(got);
    end
  end

  // Sender: bursts of random length with random gaps in between.
  task automatic send_item(logic kind, logic [7:0] ch);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i = 1'b1;
    kind_i     = kind;
    rx_byte_i  = ch;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(kind, ch);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_char(logic [7:0] ch);
    send_item(KIND_BYTE, ch);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(KIND_TICK, 8'($urandom_range(255)));
  endtask

  // Wait for every expected result, then let a possible silent lookup finish.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.expected_keys.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [tked_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_position(int unsigned r, int unsigned c, bit with_col);
    send_char(tked_pkg::CH_ESC);
    send_text(with_col ? $sformatf("[%0d;%0dR", r, c) : $sformatf("[%0dR", r));
  endtask

  // Sequence long enough to hit the full-buffer replay.
  task automatic send_overflow();
    send_char(tked_pkg::CH_ESC);
    send_char(tked_pkg::CH_LBR);
    repeat (60) send_char(tked_pkg::CH_0 + 8'($urandom_range(9)));
  endtask

  // One random chunk; mostly well-formed sequences, some noise.
  task automatic random_chunk();
    int pick;
    int k;
    pick = $urandom_range(99);
    if (pick < 35) begin
      k = $urandom_range(N_KEYS - 1);
      send_char(tked_pkg::CH_ESC);
      if ($urandom_range(7) == 0) send_ticks(1);
      send_text(seq_tail[k]);
    end else if (pick < 50) begin
      send_position($urandom_range(1100), $urandom_range(1100), $urandom_range(3) != 0);
    end else if (pick < 65) begin
      send_char(8'($urandom_range(255)));
    end else if (pick < 75) begin
      send_char(tked_pkg::CH_NUL);
      if ($urandom_range(1)) send_char(tked_pkg::CH_E0);
      send_char(8'($urandom_range(255)));
    end else if (pick < 85) begin
      send_ticks($urandom_range(1, 6));
    end else if (pick < 98) begin
      send_char(tked_pkg::CH_ESC);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(3))
          0:       send_char(tked_pkg::CH_0 + 8'($urandom_range(9)));
          1:       send_char(tked_pkg::CH_SEMI);
          2:       send_ticks(1);
          default: send_char(8'($urandom_range(255)));
        endcase
      end
    end else begin
      send_overflow();
    end
  endtask

  initial begin
    int phase_end;
    sb          = new();
    items_sent  = 0;
    burst_left  = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_BYTE;
    rx_byte_i   = 8'h00;
    cfg_we_i    = 1'b0;
    cfg_index_i = tked_pkg::CFG_TIMEOUT;
    cfg_wdata_i = 16'd0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at reset settings.
    send_char(8'h61);
    send_char(tked_pkg::CH_LF);
    send_char(8'hFF);
    send_char(tked_pkg::CH_NUL);       // plain byte with doorway off
    send_ticks(1);                     // tick outside a sequence
    send_char(tked_pkg::CH_ESC); send_text("[A");
    send_char(tked_pkg::CH_ESC); send_text("[24~");
    send_char(tked_pkg::CH_ESC); send_text("?w");
    send_char(tked_pkg::CH_ESC); send_text("OP");
    send_char(tked_pkg::CH_ESC); send_text("x");                // unknown, replayed raw
    send_char(tked_pkg::CH_ESC); send_char(tked_pkg::CH_NUL);   // NUL ends a sequence
    send_position(30, 120, 1'b1);                 // grows both
    send_position(10, 5, 1'b1);                   // no growth, swallowed
    send_position(2000, 999, 1'b1);               // saturates
    send_char(tked_pkg::CH_ESC); send_text("[;R");              // empty row number
    drain();

    write_reg(tked_pkg::CFG_DOORWAY, 16'd1);
    write_reg(tked_pkg::CFG_TIMEOUT, 16'd2);
    write_reg(CFG_SPARE, 16'hFFFF);
    send_char(tked_pkg::CH_NUL); send_char(8'h48);
    send_char(tked_pkg::CH_NUL); send_char(tked_pkg::CH_E0); send_char(8'h4D);
    send_char(tked_pkg::CH_ESC); send_char(tked_pkg::CH_LBR); send_ticks(2);  // idle timeout
    send_overflow();
    drain();

    // Random phases, each with its own register setting; they share what is
    // left of the item budget.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(tked_pkg::CFG_TIMEOUT, 16'd0);
          write_reg(tked_pkg::CFG_DOORWAY, 16'd0);
        end
        1: begin
          write_reg(tked_pkg::CFG_TIMEOUT, 16'd65535);
          write_reg(tked_pkg::CFG_DOORWAY, 16'd1);
        end
        2: begin
          write_reg(tked_pkg::CFG_TIMEOUT, 16'd1);
          write_reg(tked_pkg::CFG_DOORWAY, 16'd1);
        end
        3: begin
          write_reg(tked_pkg::CFG_TIMEOUT, 16'd3);
          write_reg(tked_pkg::CFG_DOORWAY, 16'd0);
        end
        default: begin
          write_reg(tked_pkg::CFG_TIMEOUT, 16'($urandom_range(1, 8)));
          write_reg(tked_pkg::CFG_DOORWAY, 16'($urandom_range(1)));
        end
      endcase
      phase_end = items_sent;
      if (items_sent < int'(ITEM_TARGET))
        phase_end = items_sent + (int'(ITEM_TARGET) - items_sent) / (5 - ph);
      while (items_sent < phase_end) random_chunk();
      drain();
    end

    $display("Sent %0d input items, checked %0d results: %0d key matches, %0d raw replays,",
             items_sent, sb.checked, sb.key_hits, sb.replays);
    $display("%0d screen size updates, final size %0d x %0d.",
             sb.size_updates, sb.rows, sb.cols);
    if (sb.errors == 0 && sb.expected_keys.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.expected_keys.size() != 0)
        $error("%0d expected results never arrived", sb.expected_keys.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
